>>> hdl/tmm_pkg.sv
`default_nettype none

package tmm_pkg;

    // field widths
    localparam int unsigned KEYS_W   = 8;
    localparam int unsigned AXIS_W   = 16;
    localparam int unsigned SQ_W     = 32;
    localparam int unsigned NORM_W   = 32;
    localparam int unsigned TICK_W   = 6;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned MLIM_W   = 7;
    localparam int unsigned LEVEL_W  = 17;
    localparam int unsigned CODE_W   = 4;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_LVL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HELD_LVL  = 3'd5;

    // register reset values
    localparam logic [NORM_W-1:0]  RST_GRAVITY  = 32'd0;
    localparam logic [TICK_W-1:0]  RST_TICK     = 6'd10;
    localparam logic [COUNT_W-1:0] RST_FALL_LIM = 8'd20;
    localparam logic [MLIM_W-1:0]  RST_MOVE_LIM = 7'd100;
    localparam logic [LEVEL_W-1:0] RST_FREE_LVL = 17'd5000;
    localparam logic [LEVEL_W-1:0] RST_HELD_LVL = 17'd2000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    // transition codes
    localparam logic [CODE_W-1:0] TR_NONE      = 4'd0;
    localparam logic [CODE_W-1:0] TR_TOUCH     = 4'd1;
    localparam logic [CODE_W-1:0] TR_FALL      = 4'd2;
    localparam logic [CODE_W-1:0] TR_RELEASE   = 4'd3;
    localparam logic [CODE_W-1:0] TR_STILL_GRIP = 4'd4;
    localparam logic [CODE_W-1:0] TR_MOVE      = 4'd5;
    localparam logic [CODE_W-1:0] TR_THROW     = 4'd6;
    localparam logic [CODE_W-1:0] TR_MOVE_GRIP = 4'd7;
    localparam logic [CODE_W-1:0] TR_STOP      = 4'd8;
    localparam logic [CODE_W-1:0] TR_CATCH     = 4'd9;
    localparam logic [CODE_W-1:0] TR_HALT      = 4'd10;

    // manipulation phases
    localparam logic [PHASE_W-1:0] PH_FREE_STILL = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HELD_STILL = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HELD_MOVE  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_FREE_MOVE  = 2'd3;

    typedef struct packed {
        logic [NORM_W-1:0]  gravity_norm;
        logic [TICK_W-1:0]  tick_period;
        logic [COUNT_W-1:0] freefall_limit;
        logic [MLIM_W-1:0]  motion_limit;
        logic [LEVEL_W-1:0] free_accel_level;
        logic [LEVEL_W-1:0] held_accel_level;
    } t_cfg;

    typedef struct packed {
        logic              ready;
        logic [KEYS_W-1:0] keys;
    } t_touch;

    typedef struct packed {
        logic [CODE_W-1:0]  transition;
        logic [KEYS_W-1:0]  grip;
        logic [PHASE_W-1:0] phase;
        logic               falling;
        logic               moving;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/tmm_norm_pipe.sv
`default_nettype none

module tmm_norm_pipe #(
    parameter int unsigned NORM_SHIFT = 15,
    parameter int unsigned DEV_W      = 32 - NORM_SHIFT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire tmm_pkg::t_touch                  i_touch,
    input  wire logic signed [tmm_pkg::AXIS_W-1:0] i_ax,
    input  wire logic signed [tmm_pkg::AXIS_W-1:0] i_ay,
    input  wire logic signed [tmm_pkg::AXIS_W-1:0] i_az,
    input  wire logic [tmm_pkg::NORM_W-1:0]       i_gravity,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output tmm_pkg::t_touch                       o_touch,
    output logic [DEV_W-1:0]                      o_dev
);
    import tmm_pkg::*;

    // stage a: raw sample
    logic                      r_a_valid;
    t_touch                    r_a_touch;
    logic signed [AXIS_W-1:0]  r_ax, r_ay, r_az;
    // stage b: squares
    logic                      r_b_valid;
    t_touch                    r_b_touch;
    logic [SQ_W-1:0]           r_sx, r_sy, r_sz;
    // stage c: deviation
    logic                      r_c_valid;
    t_touch                    r_c_touch;
    logic [DEV_W-1:0]          r_dev;

    logic a_ready, b_ready, c_ready;
    logic [NORM_W-1:0] norm, diff, shifted;

    function automatic logic [AXIS_W-1:0] mag(input logic signed [AXIS_W-1:0] v);
        // most negative value maps onto itself, which reads right as unsigned
        return v[AXIS_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [SQ_W-1:0] square(input logic signed [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] m;
        m = mag(v);
        return SQ_W'(m) * SQ_W'(m);
    endfunction

    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // squares are at most 2^30, so three of them fit 32 bits
    assign norm    = r_sx + r_sy + r_sz;
    assign diff    = (norm >= i_gravity) ? (norm - i_gravity) : (i_gravity - norm);
    assign shifted = diff >> NORM_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= i_valid;
            if (b_ready) r_b_valid <= r_a_valid;
            if (c_ready) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_touch <= i_touch;
            r_ax      <= i_ax;
            r_ay      <= i_ay;
            r_az      <= i_az;
        end
        if (b_ready) begin
            r_b_touch <= r_a_touch;
            r_sx      <= square(r_ax);
            r_sy      <= square(r_ay);
            r_sz      <= square(r_az);
        end
        if (c_ready) begin
            r_c_touch <= r_b_touch;
            r_dev     <= shifted[DEV_W-1:0];
        end
    end

    assign o_valid = r_c_valid;
    assign o_touch = r_c_touch;
    assign o_dev   = r_dev;

endmodule

`default_nettype wire

>>> hdl/tmm_track.sv
`default_nettype none

module tmm_track #(
    parameter int unsigned DEV_W = 17
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tmm_pkg::t_cfg     i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire tmm_pkg::t_touch   i_touch,
    input  wire logic [DEV_W-1:0]  i_dev,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output tmm_pkg::t_result       o_result
);
    import tmm_pkg::*;

    localparam int unsigned CMP_W = (DEV_W > LEVEL_W) ? DEV_W : LEVEL_W;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [KEYS_W-1:0]  r_touch, n_touch;
    logic [COUNT_W-1:0] r_ff_cnt, n_ff_cnt;
    logic [COUNT_W-1:0] r_mv_cnt, n_mv_cnt;
    logic               r_fall_last, r_move_last;
    logic               r_out_valid;
    t_result            r_result, n_result;

    logic               take, new_grip, new_fall, new_move, fall_now, move_now;
    logic               over_free, over_held;
    logic [CMP_W-1:0]   dev_x;
    logic [COUNT_W:0]   ff_room, mv_sum;
    logic [COUNT_W-1:0] tick_x, mv_cap;
    logic [CODE_W-1:0]  code;

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;

    assign new_grip = i_touch.ready && (i_touch.keys != r_touch);
    assign n_touch  = i_touch.ready ? i_touch.keys : r_touch;

    assign dev_x     = CMP_W'(i_dev);
    assign over_free = dev_x > CMP_W'(i_cfg.free_accel_level);
    assign over_held = dev_x > CMP_W'(i_cfg.held_accel_level);
    assign tick_x    = COUNT_W'(i_cfg.tick_period);
    assign ff_room   = {1'b0, COUNT_MAX} - {1'b0, tick_x};
    assign mv_sum    = {1'b0, r_mv_cnt} + {1'b0, tick_x};
    assign mv_cap    = {i_cfg.motion_limit, 1'b0};

    // history counts
    always_comb begin
        n_ff_cnt = r_ff_cnt;
        n_mv_cnt = r_mv_cnt;
        if (n_touch == '0) begin
            n_mv_cnt = '0;
            if (over_free) begin
                if ({1'b0, r_ff_cnt} <= ff_room) n_ff_cnt = r_ff_cnt + tick_x;
            end else begin
                n_ff_cnt = '0;
            end
        end else if (over_held) begin
            if (r_mv_cnt <= mv_cap) n_mv_cnt = mv_sum[COUNT_W] ? COUNT_MAX : mv_sum[COUNT_W-1:0];
        end else if (r_mv_cnt >= tick_x) begin
            n_mv_cnt = r_mv_cnt - tick_x;
        end
    end

    assign fall_now = n_ff_cnt > i_cfg.freefall_limit;
    assign move_now = n_mv_cnt > COUNT_W'(i_cfg.motion_limit);
    assign new_fall = fall_now != r_fall_last;
    assign new_move = move_now != r_move_last;

    // manipulation phase
    always_comb begin
        n_phase = r_phase;
        code    = TR_NONE;
        unique case (r_phase)
            PH_FREE_STILL: begin
                if (new_grip) begin
                    n_phase = PH_HELD_STILL; code = TR_TOUCH;
                end else if (new_fall) begin
                    n_phase = PH_FREE_MOVE; code = TR_FALL;
                end
            end
            PH_HELD_STILL: begin
                if (new_grip) begin
                    if (n_touch == '0) begin
                        n_phase = PH_FREE_STILL; code = TR_RELEASE;
                    end else begin
                        code = TR_STILL_GRIP;
                    end
                end else if (new_move) begin
                    n_phase = PH_HELD_MOVE; code = TR_MOVE;
                end
            end
            PH_HELD_MOVE: begin
                if (new_grip) begin
                    if (n_touch == '0) begin
                        n_phase = PH_FREE_MOVE; code = TR_THROW;
                    end else begin
                        code = TR_MOVE_GRIP;
                    end
                end else if (new_move) begin
                    n_phase = PH_HELD_STILL; code = TR_STOP;
                end
            end
            default: begin
                if (new_grip) begin
                    n_phase = PH_HELD_MOVE; code = TR_CATCH;
                end else if (n_mv_cnt == '0) begin
                    n_phase = PH_FREE_STILL; code = TR_HALT;
                end
            end
        endcase
    end

    always_comb begin
        n_result.transition = code;
        n_result.grip       = n_touch;
        n_result.phase      = n_phase;
        n_result.falling    = fall_now;
        n_result.moving     = move_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FREE_STILL;
            r_touch     <= '0;
            r_ff_cnt    <= '0;
            r_mv_cnt    <= '0;
            r_fall_last <= 1'b0;
            r_move_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase     <= n_phase;
                r_touch     <= n_touch;
                r_ff_cnt    <= n_ff_cnt;
                r_mv_cnt    <= n_mv_cnt;
                r_fall_last <= fall_now;
                r_move_last <= move_now;
            end
            if (o_ready) r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> hdl/touch_motion_manipulation_fsm.sv
`default_nettype none

// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+----------------------------------
// sample    | in        | i_s_tvalid / o_s_tready      | i_s_tdata, i_s_tuser
// result    | out       | o_m_tvalid / i_m_tready      | o_m_tdata
// config    | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// one item per clock sustained while the result side accepts; an accepted sample passes the
// input, square and deviation registers in turn, then the result register
// the per-item state update sits in the result stage, so items chain back to back
// synchronous active-low reset clears all counts, phase, grip and valid bits
// every stage holds while its downstream neighbor stalls; config is always ready

module touch_motion_manipulation_fsm #(
    parameter int unsigned NORM_SHIFT = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // sample items
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [55:0] i_s_tdata,   // touch_keys[7:0], accel_x[23:8], accel_y[39:24], accel_z[55:40]
    input  wire logic        i_s_tuser,   // touch_ready[0]
    // result items
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // transition[3:0], grip[11:4], phase[13:12], falling[14], moving[15]
    // register writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [tmm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tmm_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import tmm_pkg::*;

    localparam int unsigned DEV_W = 32 - NORM_SHIFT;

    t_cfg     r_cfg;
    t_touch   s_touch, p_touch;
    logic     p_valid, p_ready;
    logic [DEV_W-1:0] p_dev;
    t_result  result;

    // configuration registers, always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity_norm     <= RST_GRAVITY;
            r_cfg.tick_period      <= RST_TICK;
            r_cfg.freefall_limit   <= RST_FALL_LIM;
            r_cfg.motion_limit     <= RST_MOVE_LIM;
            r_cfg.free_accel_level <= RST_FREE_LVL;
            r_cfg.held_accel_level <= RST_HELD_LVL;
        end else if (i_cfg_valid) begin
            // unknown indexes are dropped
            unique case (i_cfg_index)
                CFG_GRAVITY:  r_cfg.gravity_norm     <= i_cfg_data[NORM_W-1:0];
                CFG_TICK:     r_cfg.tick_period      <= i_cfg_data[TICK_W-1:0];
                CFG_FALL_LIM: r_cfg.freefall_limit   <= i_cfg_data[COUNT_W-1:0];
                CFG_MOVE_LIM: r_cfg.motion_limit     <= i_cfg_data[MLIM_W-1:0];
                CFG_FREE_LVL: r_cfg.free_accel_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_HELD_LVL: r_cfg.held_accel_level <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_touch.ready = i_s_tuser;
    assign s_touch.keys  = i_s_tdata[7:0];

    // squares and gravity deviation
    tmm_norm_pipe #(
        .NORM_SHIFT (NORM_SHIFT),
        .DEV_W      (DEV_W)
    ) u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_touch   (s_touch),
        .i_ax      (i_s_tdata[23:8]),
        .i_ay      (i_s_tdata[39:24]),
        .i_az      (i_s_tdata[55:40]),
        .i_gravity (r_cfg.gravity_norm),
        .o_valid   (p_valid),
        .i_ready   (p_ready),
        .o_touch   (p_touch),
        .o_dev     (p_dev)
    );

    // counts, flag edges and manipulation phase
    tmm_track #(
        .DEV_W (DEV_W)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (p_valid),
        .o_ready  (p_ready),
        .i_touch  (p_touch),
        .i_dev    (p_dev),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result)
    );

    assign o_m_tdata = {result.moving, result.falling, result.phase,
                        result.grip, result.transition};

endmodule

`default_nettype wire
